>>> design/ole_pkg.sv
// Shared codes and types for the ordered list engine.
// Depends on nothing; ordered_list_engine_unit and the testbench import it.
package ole_pkg;

  // Command codes
  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_DEL_POS = 3'd2;
  localparam logic [2:0] CMD_DEL_VAL = 3'd3;
  localparam logic [2:0] CMD_FIND    = 3'd4;
  localparam logic [2:0] CMD_SORT    = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BOUNDS   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SCAN,
    S_SORT,
    S_FINISH
  } ole_state_t;

endpackage

>>> design/ole_if.sv
// Valid/ready channel interfaces for commands and results.
// Standalone; used by the top level ordered_list_engine_unit.
interface ole_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface ole_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] found_position;
  logic [6:0] list_count;

  modport source (output valid, status, found_position, list_count, input ready);
  modport sink   (input valid, status, found_position, list_count, output ready);
endinterface

>>> design/ole_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the list entries.
module ole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ordered_list_engine_unit.sv
// Ordered list engine: bounded list of signed 32-bit entries in one RAM.
// Append, insert at the end, rejected and unknown commands and sorts of fewer than two entries
// go straight to the result state; insert or delete at a position shifts the entries behind it,
// a value delete scans from the front and then shifts, a find scans until a hit or the end, and
// a sort runs bubble passes whose length starts at count and shrinks, at most count-1 passes.
// One command at a time, ready again as the result loads; reset clears the count.
module ordered_list_engine_unit
  import ole_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  ole_in_if.sink     in_chan,
  ole_out_if.source  out_chan
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  ole_state_t     state_r, state_nxt;
  logic [2:0]     cmd_r, cmd_nxt;
  logic [31:0]    key_r, key_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [CW-1:0]  len_r, len_nxt;
  logic [AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]  didx_r, didx_nxt;
  logic           dv_r, dv_nxt;
  logic [31:0]    hold_r, hold_nxt;
  logic           swapped_r, swapped_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [AW-1:0]  found_r, found_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     out_status_r, out_status_nxt;
  logic [5:0]     out_found_r, out_found_nxt;
  logic [6:0]     out_count_r, out_count_nxt;

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr;
  logic [31:0]    mem_wdata, mem_rdata;

  logic           in_fire, issue, match, cmp_eq, cmp_gt;
  logic [31:0]    pos_w, cnt_w, found_w, count_w;

  ole_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_idx_r),
    .rdata (mem_rdata)
  );

  // Compare logic on the read data: key match for scans, signed order for sort passes
  assign cmp_eq = (mem_rdata == key_r);
  assign cmp_gt = $signed(hold_r) > $signed(mem_rdata);

  assign in_chan.ready       = (state_r == S_IDLE);
  assign in_fire             = in_chan.valid && in_chan.ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.found_position = out_found_r;
  assign out_chan.list_count     = out_count_r;

  assign pos_w   = 32'(in_chan.position);
  assign cnt_w   = 32'(count_r);
  assign found_w = 32'(found_r);
  assign count_w = 32'(count_r);
  assign match   = dv_r && cmp_eq;
  assign mem_re  = issue;

  // Sequencer: next state, RAM control and result capture
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    rd_idx_nxt    = rd_idx_r;
    didx_nxt      = didx_r;
    hold_nxt      = hold_r;
    swapped_nxt   = swapped_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    issue         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = in_chan.cmd;
          key_nxt    = in_chan.value;
          status_nxt = ST_OK;
          found_nxt  = '0;
          rd_idx_nxt = '0;
          state_nxt  = S_FINISH;
          unique case (in_chan.cmd)
            CMD_APPEND: begin
              if (cnt_w >= 32'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                mem_wdata = in_chan.value;
                count_nxt = CW'(count_r + 1'b1);
              end
            end
            CMD_INSERT: begin
              if (pos_w > cnt_w) begin
                status_nxt = ST_BOUNDS;
              end else if (cnt_w >= 32'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else if (pos_w == cnt_w) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                mem_wdata = in_chan.value;
                count_nxt = CW'(count_r + 1'b1);
              end else begin
                pos_nxt    = CW'(in_chan.position);
                rem_nxt    = CW'(count_r - CW'(in_chan.position));
                rd_idx_nxt = AW'(count_r - 1'b1);
                state_nxt  = S_SHIFT_UP;
              end
            end
            CMD_DEL_POS: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ST_BOUNDS;
              end else begin
                pos_nxt    = CW'(in_chan.position);
                rem_nxt    = CW'(count_r - 1'b1 - CW'(in_chan.position));
                rd_idx_nxt = AW'(CW'(in_chan.position) + 1'b1);
                state_nxt  = S_SHIFT_DN;
              end
            end
            CMD_DEL_VAL, CMD_FIND: begin
              rem_nxt   = count_r;
              state_nxt = S_SCAN;
            end
            CMD_SORT: begin
              if (cnt_w >= 32'd2) begin
                len_nxt     = count_r;
                rem_nxt     = count_r;
                swapped_nxt = 1'b0;
                state_nxt   = S_SORT;
              end
            end
            default: begin
              // Unused command codes change nothing
            end
          endcase
        end
      end

      // Move entries up by one, highest first, then drop the new value in
      S_SHIFT_UP: begin
        issue = (rem_r != '0);
        if (issue) begin
          rd_idx_nxt = AW'(rd_idx_r - 1'b1);
          rem_nxt    = CW'(rem_r - 1'b1);
        end
        if (dv_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(didx_r + 1'b1);
          mem_wdata = mem_rdata;
        end else if (rem_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_r);
          mem_wdata = key_r;
          count_nxt = CW'(count_r + 1'b1);
          state_nxt = S_FINISH;
        end
      end

      // Move entries down by one over the removed position
      S_SHIFT_DN: begin
        issue = (rem_r != '0);
        if (issue) begin
          rd_idx_nxt = AW'(rd_idx_r + 1'b1);
          rem_nxt    = CW'(rem_r - 1'b1);
        end
        if (dv_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(didx_r - 1'b1);
          mem_wdata = mem_rdata;
        end else if (rem_r == '0) begin
          count_nxt = CW'(count_r - 1'b1);
          state_nxt = S_FINISH;
        end
      end

      // Walk entries from the front until the key matches or the list ends
      S_SCAN: begin
        issue = (rem_r != '0) && !match;
        if (issue) begin
          rd_idx_nxt = AW'(rd_idx_r + 1'b1);
          rem_nxt    = CW'(rem_r - 1'b1);
        end
        if (match) begin
          found_nxt = didx_r;
          if (cmd_r == CMD_DEL_VAL) begin
            pos_nxt    = CW'(didx_r);
            rem_nxt    = CW'(count_r - 1'b1 - CW'(didx_r));
            rd_idx_nxt = AW'(didx_r + 1'b1);
            state_nxt  = S_SHIFT_DN;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (rem_r == '0) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_FINISH;
        end
      end

      // Bubble pass: carry the largest seen so far, write back the smaller one
      S_SORT: begin
        issue = (rem_r != '0);
        if (issue) begin
          rd_idx_nxt = AW'(rd_idx_r + 1'b1);
          rem_nxt    = CW'(rem_r - 1'b1);
        end
        if (dv_r) begin
          if (didx_r == '0) begin
            hold_nxt = mem_rdata;
          end else if (cmp_gt) begin
            mem_we      = 1'b1;
            mem_waddr   = AW'(didx_r - 1'b1);
            mem_wdata   = mem_rdata;
            swapped_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(didx_r - 1'b1);
            mem_wdata = hold_r;
            hold_nxt  = mem_rdata;
          end
        end else if (rem_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(len_r - 1'b1);
          mem_wdata = hold_r;
          if (swapped_r && (len_r > CW'(2))) begin
            len_nxt     = CW'(len_r - 1'b1);
            rem_nxt     = CW'(len_r - 1'b1);
            rd_idx_nxt  = '0;
            swapped_nxt = 1'b0;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end

      // Load the result register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_w[5:0];
          out_count_nxt  = count_w[6:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    dv_nxt   = issue;
    didx_nxt = issue ? rd_idx_r : didx_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    rem_r        <= rem_nxt;
    len_r        <= len_nxt;
    rd_idx_r     <= rd_idx_nxt;
    didx_r       <= didx_nxt;
    hold_r       <= hold_nxt;
    swapped_r    <= swapped_nxt;
    status_r     <= status_nxt;
    found_r      <= found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) <= 32'(count_r)))
    else $error("RAM write beyond the end of the list");

  a_sort_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT) |-> ((32'(len_r) >= 32'd2) && (len_r <= count_r)))
    else $error("sort pass length out of range");

  a_result_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && (!out_valid_r || out_chan.ready))
      |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded on finish");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for ordered_list_engine_unit: commands go through a queue-fed driver,
// replies are checked against a behavioural list model as they arrive.
// Depends on design/ole_pkg.sv, design/ole_if.sv and design/ordered_list_engine_unit.sv.
module testbench;
  import ole_pkg::*;

  localparam int CAP = 64;
  localparam int TARGET_CMDS = 1950;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [6:0]         position;
    logic signed [31:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] found_position;
    logic [6:0] list_count;
  } list_reply_t;

  typedef struct packed {
    logic [6:0]            count;
    logic [CAP-1:0][31:0]  ent;
  } list_state_t;

  typedef struct packed {
    logic      drain_first;
    list_cmd_t cmd;
  } list_job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ole_in_if  in_chan();
  ole_out_if out_chan();

  ordered_list_engine_unit #(.CAPACITY(CAP)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  list_job_t   job_q[$];
  list_reply_t reply_q[$];
  list_state_t gen_list;
  list_state_t pred_list;
  list_cmd_t   offered;
  logic signed [31:0] value_pool[8];

  int     total_cmds;
  int     sent_cnt;
  int     recv_cnt;
  int     fail_cnt;
  int     hold_left;
  logic [1:0] holds_done;
  longint cycle_cnt;
  longint cycle_limit;
  longint cycle_budget;
  int     cmd_tally[8];
  int     status_tally[4];
  int     deepest;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to a list and return the reply it gives
  function automatic list_reply_t apply_list_cmd(inout list_state_t st, input list_cmd_t c);
    list_reply_t r;
    int n;
    int hit;
    int i;
    int j;
    logic signed [31:0] t;
    r = '0;
    r.status = ST_OK;
    n = st.count;
    hit = -1;
    case (c.cmd)
      CMD_APPEND: begin
        if (n >= CAP) begin
          r.status = ST_FULL;
        end else begin
          st.ent[n] = c.value;
          n++;
        end
      end
      CMD_INSERT: begin
        if (c.position > n) begin
          r.status = ST_BOUNDS;
        end else if (n >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (i = n; i > c.position; i--) st.ent[i] = st.ent[i-1];
          st.ent[c.position] = c.value;
          n++;
        end
      end
      CMD_DEL_POS, CMD_DEL_VAL, CMD_FIND: begin
        if (c.cmd == CMD_DEL_POS) begin
          if (c.position < n) hit = c.position;
          else r.status = ST_BOUNDS;
        end else begin
          for (i = n - 1; i >= 0; i--) if (st.ent[i] == c.value) hit = i;
          if (hit < 0) r.status = ST_NOTFOUND;
          else r.found_position = hit[5:0];
        end
        // close the gap left by the removed entry
        if (hit >= 0 && c.cmd != CMD_FIND) begin
          for (i = hit; i < n - 1; i++) st.ent[i] = st.ent[i+1];
          n--;
        end
      end
      CMD_SORT: begin
        for (i = 1; i < n; i++) begin
          t = st.ent[i];
          j = i;
          while (j > 0 && $signed(st.ent[j-1]) > t) begin
            st.ent[j] = st.ent[j-1];
            j--;
          end
          st.ent[j] = t;
        end
      end
      default: ;
    endcase
    st.count = n[6:0];
    r.list_count = n[6:0];
    return r;
  endfunction

  function automatic int idle_pct(input int ph);
    return (ph == 1) ? 64 : (ph == 3) ? 12 : 0;
  endfunction

  function automatic int stall_pct(input int ph);
    return (ph == 2) ? 64 : (ph == 3) ? 12 : 0;
  endfunction

  function automatic int phase_of(input int n);
    int ph;
    ph = (total_cmds == 0) ? 0 : (n * 4) / total_cmds;
    return (ph > 3) ? 3 : ph;
  endfunction

  // Mostly values that the list holds or a small shared set, so that searches hit
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && gen_list.count != 0) return gen_list.ent[$urandom_range(0, gen_list.count - 1)];
    if (r < 70) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Queue one command and track its effect on the steering copy of the list
  task automatic push_job(input logic [2:0] c, input int p, input logic [31:0] v,
                          input logic drain);
    list_job_t jb;
    jb.drain_first = drain;
    jb.cmd.cmd = c;
    jb.cmd.position = p[6:0];
    jb.cmd.value = v;
    if (c == CMD_SORT) cycle_budget += gen_list.count * (gen_list.count + 2) + 80;
    else cycle_budget += CAP + 80;
    void'(apply_list_cmd(gen_list, jb.cmd));
    job_q.push_back(jb);
  endtask

  task automatic push_random_op();
    int r;
    int n;
    n = gen_list.count;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      push_job(CMD_APPEND, $urandom_range(0, 127), pick_value(), 1'b0);
    end else if (r < 30) begin
      push_job(CMD_INSERT, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
               : $urandom_range(0, n), pick_value(), 1'b0);
    end else if (r < 45) begin
      push_job(CMD_DEL_POS, ($urandom_range(0, 7) == 0 || n == 0) ? $urandom_range(0, 127)
               : $urandom_range(0, n - 1), $urandom, 1'b0);
    end else if (r < 62) begin
      push_job(CMD_DEL_VAL, $urandom_range(0, 127), pick_value(), 1'b0);
    end else if (r < 85) begin
      push_job(CMD_FIND, $urandom_range(0, 127), pick_value(), 1'b0);
    end else if (r < 91) begin
      // keep long sorts rare
      if (n <= 40 || $urandom_range(0, 3) == 0)
        push_job(CMD_SORT, $urandom_range(0, 127), $urandom, 1'b0);
      else
        push_job(CMD_FIND, $urandom_range(0, 127), pick_value(), 1'b0);
    end else begin
      push_job(3'($urandom_range(6, 7)), $urandom_range(0, 127), $urandom, 1'b0);
    end
  endtask

  task automatic build_stimulus();
    int target;
    int ops;
    int episode;
    int r;
    foreach (value_pool[k]) value_pool[k] = $urandom;
    value_pool[0] = 0;
    value_pool[1] = -1;
    value_pool[2] = 32'sh7fffffff;
    value_pool[3] = 32'sh80000000;
    gen_list = '0;

    // Directed: empty list corner cases, extremes, one-entry sort, duplicates
    push_job(CMD_FIND,    0,   0,            1'b0);
    push_job(CMD_DEL_VAL, 0,   5,            1'b0);
    push_job(CMD_DEL_POS, 0,   0,            1'b0);
    push_job(CMD_SORT,    0,   0,            1'b0);
    push_job(CMD_INSERT,  1,   7,            1'b0);
    push_job(CMD_INSERT,  127, $urandom,     1'b0);
    push_job(3'd6,        127, 32'hffffffff, 1'b0);
    push_job(CMD_APPEND,  0,   32'h7fffffff, 1'b0);
    push_job(CMD_SORT,    0,   0,            1'b0);
    push_job(CMD_APPEND,  0,   32'h80000000, 1'b0);
    push_job(CMD_INSERT,  0,   0,            1'b0);
    push_job(CMD_INSERT,  3,   32'hffffffff, 1'b0);
    push_job(CMD_INSERT,  5,   1,            1'b0);
    push_job(CMD_FIND,    0,   32'h80000000, 1'b0);
    push_job(CMD_DEL_POS, 4,   0,            1'b0);
    push_job(CMD_SORT,    0,   0,            1'b0);
    push_job(CMD_FIND,    0,   32'h7fffffff, 1'b0);
    push_job(CMD_APPEND,  0,   0,            1'b0);
    push_job(CMD_FIND,    0,   0,            1'b0);
    push_job(CMD_DEL_VAL, 0,   32'hffffffff, 1'b0);
    push_job(CMD_DEL_POS, gen_list.count - 1, 0, 1'b0);
    push_job(CMD_DEL_POS, 0,   0,            1'b0);
    push_job(3'd7,        $urandom_range(0, 127), $urandom, 1'b0);
    push_job(CMD_INSERT,  gen_list.count, $urandom, 1'b0);

    // Random episodes: grow to a target size, work on it, sometimes shrink
    episode = 0;
    while (job_q.size() < TARGET_CMDS) begin
      r = $urandom_range(0, 5);
      if (episode == 0 || r == 0) target = CAP;
      else if (r == 1) target = $urandom_range(21, CAP - 1);
      else target = $urandom_range(0, 20);
      if (episode == 0 || $urandom_range(0, 7) == 0)
        push_job(CMD_FIND, $urandom_range(0, 127), pick_value(), 1'b1);
      while (gen_list.count < target) begin
        if ($urandom_range(0, 1) == 0) push_job(CMD_APPEND, $urandom_range(0, 127), pick_value(), 1'b0);
        else push_job(CMD_INSERT, $urandom_range(0, gen_list.count), pick_value(), 1'b0);
      end
      if (gen_list.count == CAP) begin
        push_job(CMD_APPEND, 0, $urandom, 1'b0);
        push_job(CMD_INSERT, $urandom_range(0, CAP), $urandom, 1'b0);
        push_job(CMD_INSERT, CAP + 1, $urandom, 1'b0);
      end
      ops = $urandom_range(5, 30);
      repeat (ops) push_random_op();
      if ($urandom_range(0, 1) == 0) begin
        target = $urandom_range(0, 5);
        while (gen_list.count > target) begin
          if ($urandom_range(0, 2) == 0)
            push_job(CMD_DEL_VAL, 0, gen_list.ent[$urandom_range(0, gen_list.count - 1)], 1'b0);
          else
            push_job(CMD_DEL_POS, $urandom_range(0, gen_list.count - 1), $urandom, 1'b0);
        end
      end
      episode++;
    end
    total_cmds = job_q.size();
    cycle_limit = 4 * (cycle_budget + 2 * HOLD_CYCLES) + 20000;
  endtask

  // Driver: offer queued commands, predict each reply at the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        reply_q.push_back(apply_list_cmd(pred_list, offered));
        cmd_tally[offered.cmd]++;
        if (pred_list.count > deepest) deepest = pred_list.count;
        sent_cnt++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (job_q.size() != 0 && !(job_q[0].drain_first && reply_q.size() != 0) &&
            $urandom_range(0, 99) >= idle_pct(phase_of(sent_cnt))) begin
          offered = job_q.pop_front().cmd;
          in_chan.valid    <= 1'b1;
          in_chan.cmd      <= offered.cmd;
          in_chan.position <= offered.position;
          in_chan.value    <= offered.value;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, twice in the run
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_done <= 2'b00;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!holds_done[0] && sent_cnt >= total_cmds / 8) begin
      hold_left <= HOLD_CYCLES;
      holds_done[0] <= 1'b1;
    end else if (!holds_done[1] && sent_cnt >= (9 * total_cmds) / 16) begin
      hold_left <= HOLD_CYCLES;
      holds_done[1] <= 1'b1;
    end
  end

  // Monitor: compare each reply transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (reply_q.size() == 0) begin
          $error("reply with no command outstanding");
          fail_cnt++;
        end else begin
          if (out_chan.status !== reply_q[0].status) begin
            $error("status: expected %0d, got %0d", reply_q[0].status, out_chan.status);
            fail_cnt++;
          end
          if (out_chan.found_position !== reply_q[0].found_position) begin
            $error("found_position: expected %0d, got %0d", reply_q[0].found_position,
                   out_chan.found_position);
            fail_cnt++;
          end
          if (out_chan.list_count !== reply_q[0].list_count) begin
            $error("list_count: expected %0d, got %0d", reply_q[0].list_count,
                   out_chan.list_count);
            fail_cnt++;
          end
          status_tally[reply_q[0].status]++;
          void'(reply_q.pop_front());
        end
        recv_cnt++;
      end
      out_chan.ready <= (hold_left == 0) &&
                        ($urandom_range(0, 99) >= stall_pct(phase_of(recv_cnt)));
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_limit != 0 && cycle_cnt > cycle_limit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.cmd = CMD_APPEND;
    in_chan.position = '0;
    in_chan.value = '0;
    out_chan.ready = 1'b0;
    sent_cnt = 0;
    recv_cnt = 0;
    fail_cnt = 0;
    deepest = 0;
    cycle_cnt = 0;
    cycle_limit = 0;
    cycle_budget = 0;
    pred_list = '0;
    offered = '0;
    foreach (cmd_tally[k]) cmd_tally[k] = 0;
    foreach (status_tally[k]) status_tally[k] = 0;
    build_stimulus();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Run until every command is taken and every reply is back, then watch a little longer
    while (sent_cnt < total_cmds) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d commands: %0d appends, %0d inserts, %0d position deletes, %0d value deletes,",
             sent_cnt, cmd_tally[CMD_APPEND], cmd_tally[CMD_INSERT], cmd_tally[CMD_DEL_POS],
             cmd_tally[CMD_DEL_VAL]);
    $display("%0d finds, %0d sorts, %0d unknown; %0d full, %0d out of range, %0d misses; deepest list %0d",
             cmd_tally[CMD_FIND], cmd_tally[CMD_SORT], cmd_tally[6] + cmd_tally[7],
             status_tally[ST_FULL], status_tally[ST_BOUNDS], status_tally[ST_NOTFOUND], deepest);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
